[rtl/core/hsvc_pkg.sv]
// Shared types, constants and helper functions for the RGB/HSV color converter.
// Used by every module in rtl/core; depends on nothing else.
package hsvc_pkg;

    // Restoring divider steps, one quotient bit each (quotients stay below 512)
    localparam int NSTEP = 9;

    localparam logic ACT_RGB = 1'b0;
    localparam logic ACT_HSV = 1'b1;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    // y / 625 ~= (y * RECIP_625) >> RECIP_SHIFT, low by at most one
    localparam logic [18:0] RECIP_625   = 19'd429496;
    localparam int          RECIP_SHIFT = 28;

    typedef struct packed {
        logic       action;
        logic [9:0] chan_first;
        logic [9:0] chan_second;
        logic [9:0] chan_third;
        logic [9:0] alpha_in;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
        logic [7:0] alpha_out;
    } out_t;

    // Classified beat as it sits in the queue
    typedef struct packed {
        logic             act;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [7:0]       alpha;
        logic [8:0]       hue;
        logic [6:0]       sat;
        logic [6:0]       bri;
        logic [2:0]       sector;
        logic             gray;
        logic [16:0]      hnum;
        logic [7:0]       dlt;
        logic [14:0]      snum;
        logic [7:0]       mx;
        logic [14:0]      bnum;
        logic [3:0][12:0] kv;
    } item_t;

    // Back pipeline stage contents
    typedef struct packed {
        logic             act;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [7:0]       alpha;
        logic [8:0]       hue;
        logic [6:0]       sat;
        logic [6:0]       bri;
        logic [2:0]       sector;
        logic             gray;
        logic [16:0]      hrem;
        logic [7:0]       hdiv;
        logic [8:0]       hq;
        logic [16:0]      srem;
        logic [7:0]       sdiv;
        logic [8:0]       sq;
        logic [3:0][12:0] kv;
        logic [3:0][17:0] ly;
        logic [3:0][7:0]  lq;
        logic [14:0]      bnum;
        logic [7:0]       bq;
    } st_t;

    typedef struct packed {
        logic [16:0] rem;
        logic        qbit;
    } dstep_t;

    function automatic dstep_t div_step(input logic [16:0] rem, input logic [7:0] dv,
                                        input logic [3:0] sh);
        logic [16:0] sub;
        dstep_t      o;
        sub = 17'(dv) << sh;
        if (rem >= sub)
        begin
            o.rem  = rem - sub;
            o.qbit = 1'b1;
        end
        else
        begin
            o.rem  = rem;
            o.qbit = 1'b0;
        end
        return o;
    endfunction

    function automatic logic [7:0] clamp255(input logic [9:0] x);
        return (x > 10'd255) ? 8'd255 : x[7:0];
    endfunction

    function automatic logic [6:0] clamp100(input logic [9:0] x);
        return (x > 10'd100) ? 7'd100 : x[6:0];
    endfunction

endpackage

[rtl/core/hsvc_front.sv]
// Front end: clamps a beat and prepares divider operands for either direction.
// Depends on hsvc_pkg.
module hsvc_front
(
    input  hsvc_pkg::in_t   src,
    output hsvc_pkg::item_t item
);

    always_comb
    begin
        logic [7:0]         r, g, b, mx, mn, d;
        logic signed [18:0] num;
        logic [9:0]         hm;
        logic [8:0]         h;
        logic [6:0]         s;
        logic [2:0]         sec;
        logic [5:0]         f;
        logic [12:0]         sf, sg;

        r  = hsvc_pkg::clamp255(src.chan_first);
        g  = hsvc_pkg::clamp255(src.chan_second);
        b  = hsvc_pkg::clamp255(src.chan_third);
        mx = b;
        if (mx < g) mx = g;
        if (mx < r) mx = r;
        mn = b;
        if (mn > g) mn = g;
        if (mn > r) mn = r;
        d  = mx - mn;

        // Red wins ties, then green
        if (r == mx)
        begin
            num = 19'sd60 * (19'(signed'({1'b0, g})) - 19'(signed'({1'b0, b})));
            if (num < 0)
                num = num + 19'sd360 * 19'(signed'({1'b0, d}));
        end
        else if (g == mx)
            num = 19'sd120 * 19'(signed'({1'b0, d}))
                + 19'sd60 * (19'(signed'({1'b0, b})) - 19'(signed'({1'b0, r})));
        else
            num = 19'sd240 * 19'(signed'({1'b0, d}))
                + 19'sd60 * (19'(signed'({1'b0, r})) - 19'(signed'({1'b0, g})));

        hm = src.chan_first;
        if (hm >= 10'd720)
            hm = hm - 10'd720;
        else if (hm >= 10'd360)
            hm = hm - 10'd360;
        h = hm[8:0];
        s = hsvc_pkg::clamp100(src.chan_second);

        if (h < 9'd60)       sec = hsvc_pkg::SEC_0;
        else if (h < 9'd120) sec = hsvc_pkg::SEC_1;
        else if (h < 9'd180) sec = hsvc_pkg::SEC_2;
        else if (h < 9'd240) sec = hsvc_pkg::SEC_3;
        else if (h < 9'd300) sec = hsvc_pkg::SEC_4;
        else                 sec = hsvc_pkg::SEC_5;
        f  = 6'(h - 9'(9'd60 * 9'(sec)));
        sf = 13'(s) * 13'(f);
        sg = 13'(s) * 13'(6'd60 - f);

        item.act    = src.action;
        item.r      = r;
        item.g      = g;
        item.b      = b;
        item.alpha  = hsvc_pkg::clamp255(src.alpha_in);
        item.hue    = h;
        item.sat    = s;
        item.bri    = hsvc_pkg::clamp100(src.chan_third);
        item.sector = sec;
        item.gray   = (d == 8'd0);
        item.hnum   = 17'(num);
        item.dlt    = d;
        item.snum   = 15'(15'd100 * 15'(d));
        item.mx     = mx;
        item.bnum   = 15'(15'd100 * 15'(mx));
        item.kv[0]  = 13'd6000;
        item.kv[1]  = 13'(13'd60 * 13'(7'd100 - s));
        item.kv[2]  = 13'd6000 - sf;
        item.kv[3]  = 13'd6000 - sg;
    end

endmodule

[rtl/core/hsvc_fifo.sv]
// Two-entry queue between the front end and the back pipeline.
// Depends on hsvc_pkg.
module hsvc_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsvc_pkg::item_t wr_item,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output hsvc_pkg::item_t rd_item
);

    hsvc_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

[rtl/core/hsvc_back.sv]
// Back pipeline: restoring dividers for hue and saturation, reciprocal dividers
// for brightness and the HSV-to-RGB components, and the result register. Uses hsvc_pkg.
module hsvc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  hsvc_pkg::item_t q_item,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_stall,
    output hsvc_pkg::out_t  res_data
);

    localparam int N = hsvc_pkg::NSTEP;

    hsvc_pkg::st_t   st_reg [N];
    hsvc_pkg::st_t   st_next [N];
    logic [N-1:0]    vld_reg, vld_next;
    logic            out_vld_reg, out_vld_next;
    hsvc_pkg::out_t  out_reg, out_next;
    logic            adv;

    // Whole pipe holds only while a finished beat waits at the output
    assign adv       = !(out_vld_reg && res_stall);
    assign pop       = adv && q_valid;
    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        hsvc_pkg::st_t   cur, nxt;
        hsvc_pkg::dstep_t dh, ds;
        logic [19:0]     pk;
        logic [23:0]     x;
        logic [36:0]     p;
        logic [22:0]     pb;
        logic [17:0]     m, rr;
        logic [14:0]     mb, rb;

        cur        = '0;
        cur.act    = q_item.act;
        cur.r      = q_item.r;
        cur.g      = q_item.g;
        cur.b      = q_item.b;
        cur.alpha  = q_item.alpha;
        cur.hue    = q_item.hue;
        cur.sat    = q_item.sat;
        cur.bri    = q_item.bri;
        cur.sector = q_item.sector;
        cur.gray   = q_item.gray;
        cur.hrem   = q_item.hnum;
        cur.hdiv   = q_item.dlt;
        cur.srem   = 17'(q_item.snum);
        cur.sdiv   = q_item.mx;
        cur.kv     = q_item.kv;
        cur.bnum   = q_item.bnum;

        for (int k = 0; k < N; k++)
        begin
            nxt = cur;
            dh  = hsvc_pkg::div_step(nxt.hrem, nxt.hdiv, 4'(N - 1 - k));
            ds  = hsvc_pkg::div_step(nxt.srem, nxt.sdiv, 4'(N - 1 - k));
            nxt.hrem          = dh.rem;
            nxt.hq[N - 1 - k] = dh.qbit;
            nxt.srem          = ds.rem;
            nxt.sq[N - 1 - k] = ds.qbit;

            if (k == 0)
            begin
                // 255*v*K/600000 = 17*v*K/40000; drop the factor 64 first
                for (int j = 0; j < 4; j++)
                begin
                    pk        = 20'(nxt.bri) * 20'(nxt.kv[j]);
                    x         = (24'(pk) << 4) + 24'(pk);
                    nxt.ly[j] = 18'(x >> 6);
                end
            end
            else if (k == 1)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    p         = 37'(nxt.ly[j]) * 37'(hsvc_pkg::RECIP_625);
                    nxt.lq[j] = 8'(p >> hsvc_pkg::RECIP_SHIFT);
                end
                pb     = 23'(nxt.bnum) * 23'd257;
                nxt.bq = 8'(pb >> 16);
            end
            else if (k == 2)
            begin
                // Estimates are low by at most one: fix with one compare
                for (int j = 0; j < 4; j++)
                begin
                    m  = 18'(nxt.lq[j]) * 18'd625;
                    rr = nxt.ly[j] - m;
                    if (rr >= 18'd625)
                        nxt.lq[j] = nxt.lq[j] + 8'd1;
                end
                mb = 15'(nxt.bq) * 15'd255;
                rb = nxt.bnum - mb;
                if (rb >= 15'd255)
                    nxt.bq = nxt.bq + 8'd1;
            end

            st_next[k] = nxt;
            cur        = st_reg[k];
        end
    end

    always_comb
    begin
        hsvc_pkg::st_t l;
        logic [7:0]    vv, pp, qq, tt;

        l  = st_reg[N-1];
        vv = l.lq[0];
        pp = l.lq[1];
        qq = l.lq[2];
        tt = l.lq[3];
        out_next.alpha_out = l.alpha;
        if (l.act == hsvc_pkg::ACT_RGB)
        begin
            out_next.red        = l.r;
            out_next.green      = l.g;
            out_next.blue       = l.b;
            out_next.brightness = l.bq[6:0];
            if (l.gray)
            begin
                out_next.hue        = 9'd0;
                out_next.saturation = 7'd0;
            end
            else
            begin
                out_next.hue        = (l.hq >= 9'd360) ? l.hq - 9'd360 : l.hq;
                out_next.saturation = l.sq[6:0];
            end
        end
        else
        begin
            out_next.hue        = l.hue;
            out_next.saturation = l.sat;
            out_next.brightness = l.bri;
            case (l.sector)
                hsvc_pkg::SEC_0:
                begin
                    out_next.red = vv; out_next.green = tt; out_next.blue = pp;
                end
                hsvc_pkg::SEC_1:
                begin
                    out_next.red = qq; out_next.green = vv; out_next.blue = pp;
                end
                hsvc_pkg::SEC_2:
                begin
                    out_next.red = pp; out_next.green = vv; out_next.blue = tt;
                end
                hsvc_pkg::SEC_3:
                begin
                    out_next.red = pp; out_next.green = qq; out_next.blue = vv;
                end
                hsvc_pkg::SEC_4:
                begin
                    out_next.red = tt; out_next.green = pp; out_next.blue = vv;
                end
                default:
                begin
                    out_next.red = vv; out_next.green = pp; out_next.blue = qq;
                end
            endcase
        end
    end

    always_comb
    begin
        vld_next     = {vld_reg[N-2:0], q_valid};
        out_vld_next = vld_reg[N-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
                st_reg[k] <= st_next[k];
            out_reg <= out_next;
        end
    end

endmodule

[rtl/core/rgb_hsv_color_converter.sv]
// RGB/HSV color converter. Each beat sets a color either from RGB (action 0) or
// from HSV (action 1) plus alpha, and returns all seven values. One beat per cycle
// is taken and delivered while the output is not stalled; an accepted beat passes through the
// queue, nine divider stages and then the result register. The pipeline depth is set by the
// nine-step restoring dividers for hue and saturation. A two-beat queue takes in up to two
// beats while a finished result waits under stall; once it is full, src_stall is raised.
module rgb_hsv_color_converter
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  hsvc_pkg::in_t  src_data,
    output logic           res_valid,
    input  logic           res_stall,
    output hsvc_pkg::out_t res_data
);

    hsvc_pkg::item_t f_item, q_item;
    logic            q_full, q_valid, q_pop, push;

    assign src_stall = q_full;
    assign push      = src_valid && !q_full;

    hsvc_front u_front
    (
        .src  (src_data),
        .item (f_item)
    );

    hsvc_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (f_item),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_valid),
        .rd_item  (q_item)
    );

    hsvc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef ASSERT_OFF
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.hue < 9'd360) && (res_data.saturation <= 7'd100)
                      && (res_data.brightness <= 7'd100))
        else $error("result field out of range");

    a_queued: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("accepted beat missing from queue");

    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !(res_valid && res_stall))
        else $error("queue popped while empty or held");
`endif

endmodule
